/* rtl/core/swsu_pkg.sv */
// Shared constants and codes of the stop-and-wait sender.
package swsu_pkg;

	localparam int BUF_DEPTH = 1024;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int SEQ_W     = 33;
	localparam int RSEQ_W    = 32;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_START   = 2'd1;
	localparam logic [1:0] CMD_REPLY   = 2'd2;
	localparam logic [1:0] CMD_TIMEOUT = 2'd3;

	localparam logic [2:0] KIND_SYN      = 3'd0;
	localparam logic [2:0] KIND_DATA     = 3'd1;
	localparam logic [2:0] KIND_FIN      = 3'd2;
	localparam logic [2:0] KIND_FINISHED = 3'd3;
	localparam logic [2:0] KIND_GAVE_UP  = 3'd4;

	localparam logic [1:0] HDR_DATA = 2'd0;
	localparam logic [1:0] HDR_FIN  = 2'd1;
	localparam logic [1:0] HDR_SYN  = 2'd2;

	localparam logic [7:0] RHDR_ACK     = 8'h04;
	localparam logic [7:0] RHDR_FIN_ACK = 8'h05;
	localparam logic [7:0] RHDR_SYN_ACK = 8'h06;

	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_LF  = 8'h0A;

	localparam logic [7:0] FIN_TRIES_RESET = 8'd25;

endpackage

/* rtl/core/stop_and_wait_sender_unit.sv */
// Stop-and-wait ARQ sender: message buffer, SYN handshake, data transfer and FIN teardown.
//
// One request is taken per clock. A request is accepted into stage 0, where the message
// buffer (a synchronous RAM with one read and one write port) is read; the next cycle
// stage 1 makes the protocol decision with the read byte and places any packet report into
// the output register, which takes it once stage 1 advances past any waiting report.
// The buffer address for a request is forwarded from the decision of the request
// just ahead of it, which keeps the rate at one request per cycle; the only stall comes
// from the output side holding tready low while a report waits. The buffer needs no
// clearing after reset.
module stop_and_wait_sender_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // load_byte[7:0], reply_header[15:8], reply_seq[47:16]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // header_out[1:0], seq_out[34:2], data_out[42:35], zero
	output logic [2:0]  m_tuser,   // kind[2:0]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata  // fin_tries
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_SYN  = 4'b0010,
		PH_DATA = 4'b0100,
		PH_FIN  = 4'b1000
	} phase_t;

	localparam int AW = swsu_pkg::ADDR_W;
	localparam int CW = swsu_pkg::CNT_W;
	localparam int SW = swsu_pkg::SEQ_W;

	// architectural state
	phase_t          phase_q;
	logic [SW-1:0]   next_seq_q;
	logic [7:0]      fin_count_q;
	logic [CW-1:0]   loaded_q;
	logic [7:0]      fin_tries_q;

	// stage 1
	logic            valid_s1;
	logic [1:0]      cmd_s1;
	logic [7:0]      byte_s1;
	logic [7:0]      hdr_s1;
	logic            rseq_zero_s1;
	logic [SW-1:0]   rinc_s1;
	logic [7:0]      rd_data_s1;

	// output register
	logic            out_valid_q;
	logic [2:0]      out_kind_q;
	logic [1:0]      out_hdr_q;
	logic [SW-1:0]   out_seq_q;
	logic [7:0]      out_data_q;

	logic [7:0] mem [swsu_pkg::BUF_DEPTH];

	// stage 0 fields
	logic [1:0]                in_cmd;
	logic [7:0]                in_byte;
	logic [7:0]                in_hdr;
	logic [swsu_pkg::RSEQ_W-1:0] in_rseq;

	assign in_cmd  = s_tuser;
	assign in_byte = s_tdata[7:0];
	assign in_hdr  = s_tdata[15:8];
	assign in_rseq = s_tdata[47:16];

	// stage 1 decision
	phase_t        ph_nx;
	logic [SW-1:0] ns_nx;
	logic [7:0]    fc_nx;
	logic [CW-1:0] lc_nx;
	logic          mem_we;
	logic          res_vld;
	logic [2:0]    res_kind;
	logic [1:0]    res_hdr;
	logic [SW-1:0] res_seq;
	logic [7:0]    res_data;
	logic          evt_s1;
	logic          got_s1;
	logic          syn_ok_s1;
	logic          ack_s1;
	logic [SW-1:0] ns_new;
	logic          in_range;
	logic          done;

	always_comb begin
		evt_s1    = (cmd_s1 == swsu_pkg::CMD_REPLY) || (cmd_s1 == swsu_pkg::CMD_TIMEOUT);
		got_s1    = (cmd_s1 == swsu_pkg::CMD_REPLY);
		syn_ok_s1 = got_s1 && (hdr_s1 == swsu_pkg::RHDR_SYN_ACK) && rseq_zero_s1;
		ack_s1    = got_s1 && (hdr_s1 == swsu_pkg::RHDR_ACK);
		if (phase_q == PH_DATA && ack_s1) begin
			ns_new = rinc_s1;
		end else if (phase_q == PH_SYN) begin
			ns_new = SW'(1);
		end else begin
			ns_new = next_seq_q;
		end
		in_range = (ns_new != '0) && (ns_new <= SW'(loaded_q));
		done     = !in_range || (rd_data_s1 == swsu_pkg::BYTE_NUL)
			|| (rd_data_s1 == swsu_pkg::BYTE_LF);

		ph_nx    = phase_q;
		ns_nx    = next_seq_q;
		fc_nx    = fin_count_q;
		lc_nx    = loaded_q;
		mem_we   = 1'b0;
		res_vld  = 1'b0;
		res_kind = swsu_pkg::KIND_SYN;
		res_hdr  = swsu_pkg::HDR_DATA;
		res_seq  = '0;
		res_data = '0;

		case (phase_q)
			PH_IDLE: begin
				if (cmd_s1 == swsu_pkg::CMD_LOAD) begin
					if (loaded_q < CW'(swsu_pkg::BUF_DEPTH)) begin
						mem_we = 1'b1;
						lc_nx  = loaded_q + CW'(1);
					end
				end else if (cmd_s1 == swsu_pkg::CMD_START) begin
					ph_nx    = PH_SYN;
					ns_nx    = '0;
					fc_nx    = '0;
					res_vld  = 1'b1;
					res_kind = swsu_pkg::KIND_SYN;
					res_hdr  = swsu_pkg::HDR_SYN;
				end
			end
			PH_SYN, PH_DATA: begin
				if (evt_s1) begin
					res_vld = 1'b1;
					if (phase_q == PH_SYN && !syn_ok_s1) begin
						res_kind = swsu_pkg::KIND_SYN;
						res_hdr  = swsu_pkg::HDR_SYN;
					end else begin
						ns_nx   = ns_new;
						res_seq = ns_new;
						if (done) begin
							ph_nx    = PH_FIN;
							fc_nx    = 8'd1;
							res_kind = swsu_pkg::KIND_FIN;
							res_hdr  = swsu_pkg::HDR_FIN;
						end else begin
							ph_nx    = PH_DATA;
							res_kind = swsu_pkg::KIND_DATA;
							res_hdr  = swsu_pkg::HDR_DATA;
							res_data = rd_data_s1;
						end
					end
				end
			end
			PH_FIN: begin
				if (evt_s1) begin
					res_vld = 1'b1;
					if ((got_s1 && hdr_s1 == swsu_pkg::RHDR_FIN_ACK)
						|| fin_count_q >= fin_tries_q) begin
						ph_nx    = PH_IDLE;
						lc_nx    = '0;
						fc_nx    = '0;
						res_kind = (got_s1 && hdr_s1 == swsu_pkg::RHDR_FIN_ACK)
							? swsu_pkg::KIND_FINISHED : swsu_pkg::KIND_GAVE_UP;
					end else begin
						fc_nx    = fin_count_q + 8'd1;
						res_kind = swsu_pkg::KIND_FIN;
						res_hdr  = swsu_pkg::HDR_FIN;
						res_seq  = next_seq_q;
					end
				end
			end
			default: begin
				ph_nx = PH_IDLE;
			end
		endcase
	end

	logic s1_adv;
	logic s_fire;

	assign s1_adv   = valid_s1 && (!res_vld || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign s_fire   = s_tvalid && s_tready;

	// buffer address forwarded from the stage 1 decision
	phase_t        ph_eff;
	logic [SW-1:0] ns_eff;
	logic [AW-1:0] rd_addr;

	always_comb begin
		ph_eff = valid_s1 ? ph_nx : phase_q;
		ns_eff = valid_s1 ? ns_nx : next_seq_q;
		if (ph_eff == PH_DATA && in_cmd == swsu_pkg::CMD_REPLY
			&& in_hdr == swsu_pkg::RHDR_ACK) begin
			rd_addr = in_rseq[AW-1:0];
		end else if (ph_eff == PH_SYN) begin
			rd_addr = '0;
		end else begin
			rd_addr = ns_eff[AW-1:0] - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && s1_adv) begin
			mem[loaded_q[AW-1:0]] <= byte_s1;
		end
		if (s_fire) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1       <= in_cmd;
			byte_s1      <= in_byte;
			hdr_s1       <= in_hdr;
			rseq_zero_s1 <= (in_rseq == '0);
			rinc_s1      <= SW'(in_rseq) + SW'(1);
		end
		if (s1_adv && res_vld) begin
			out_kind_q <= res_kind;
			out_hdr_q  <= res_hdr;
			out_seq_q  <= res_seq;
			out_data_q <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			next_seq_q  <= '0;
			fin_count_q <= '0;
			loaded_q    <= '0;
			fin_tries_q <= swsu_pkg::FIN_TRIES_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fin_tries_q <= cfg_wdata;
			end
			if (s1_adv) begin
				phase_q     <= ph_nx;
				next_seq_q  <= ns_nx;
				fin_count_q <= fc_nx;
				loaded_q    <= lc_nx;
			end
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv && res_vld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {5'd0, out_data_q, out_seq_q, out_hdr_q};

endmodule

/* rtl/core/swsu_checker.sv */
// Port-level checks of the stop-and-wait sender, bound into the sender unit.
module swsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// stalled report stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("report dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= swsu_pkg::KIND_GAVE_UP)
		else $error("bad report kind");

	a_syn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == swsu_pkg::KIND_SYN
		|-> m_tdata[1:0] == swsu_pkg::HDR_SYN && m_tdata[47:2] == '0)
		else $error("malformed SYN report");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == swsu_pkg::KIND_FINISHED || m_tuser == swsu_pkg::KIND_GAVE_UP)
		|-> m_tdata == '0)
		else $error("end report carries payload");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == swsu_pkg::KIND_DATA
		|-> m_tdata[1:0] == swsu_pkg::HDR_DATA && m_tdata[34:2] != '0)
		else $error("malformed data report");

endmodule

bind stop_and_wait_sender_unit swsu_checker u_swsu_checker (.*);

/* tb/testbench.sv */
// Self-checking bench for the stop-and-wait sender: directed handshakes, then random messages.
module testbench;

	typedef enum logic [1:0] {PH_IDLE, PH_SYN, PH_DATA, PH_FIN} link_phase_t;

	typedef struct {
		logic [2:0]                 kind;
		logic [1:0]                 hdr;
		logic [swsu_pkg::SEQ_W-1:0] seq;
		logic [7:0]                 data;
	} packet_t;

	class sender_mirror;
		logic [7:0]                 fin_tries = swsu_pkg::FIN_TRIES_RESET;
		link_phase_t                phase = PH_IDLE;
		logic [swsu_pkg::SEQ_W-1:0] next_seq = '0;
		logic [7:0]                 fin_count = '0;
		int                         loaded = 0;
		logic [7:0]                 message[swsu_pkg::BUF_DEPTH];
		packet_t                    packets_due[$];
		int                         requests = 0;
		int                         mismatches = 0;

		function void push_packet(logic [2:0] k, logic [1:0] h,
				logic [swsu_pkg::SEQ_W-1:0] s, logic [7:0] d);
			packet_t p;
			p.kind = k;
			p.hdr  = h;
			p.seq  = s;
			p.data = d;
			packets_due.push_back(p);
		endfunction

		function bit data_done();
			logic [swsu_pkg::SEQ_W-1:0] idx;
			logic [7:0]                 b;
			if (next_seq == 0)
				return 1;
			idx = next_seq - 1'b1;
			if (idx >= loaded || idx >= swsu_pkg::BUF_DEPTH)
				return 1;
			b = message[idx[swsu_pkg::ADDR_W-1:0]];
			return (b == swsu_pkg::BYTE_NUL) || (b == swsu_pkg::BYTE_LF);
		endfunction

		function void send_data_or_fin();
			if (data_done()) begin
				phase = PH_FIN;
				fin_count = 8'd1;
				push_packet(swsu_pkg::KIND_FIN, swsu_pkg::HDR_FIN, next_seq, 8'h00);
			end else begin
				phase = PH_DATA;
				push_packet(swsu_pkg::KIND_DATA, swsu_pkg::HDR_DATA, next_seq,
					message[next_seq - 1'b1]);
			end
		endfunction

		function void close_link(logic [2:0] k);
			phase = PH_IDLE;
			loaded = 0;
			fin_count = '0;
			push_packet(k, swsu_pkg::HDR_DATA, '0, 8'h00);
		endfunction

		// predict the packet, if any, caused by one accepted request
		function void take_request(logic [1:0] cmd, logic [7:0] msg_byte, logic [7:0] rhdr,
				logic [swsu_pkg::RSEQ_W-1:0] rseq);
			bit got;
			requests++;
			got = (cmd == swsu_pkg::CMD_REPLY);
			if (phase == PH_IDLE) begin
				if (cmd == swsu_pkg::CMD_LOAD && loaded < swsu_pkg::BUF_DEPTH) begin
					message[loaded] = msg_byte;
					loaded++;
				end else if (cmd == swsu_pkg::CMD_START) begin
					phase = PH_SYN;
					next_seq = '0;
					fin_count = '0;
					push_packet(swsu_pkg::KIND_SYN, swsu_pkg::HDR_SYN, '0, 8'h00);
				end
				return;
			end
			if (cmd == swsu_pkg::CMD_LOAD || cmd == swsu_pkg::CMD_START)
				return;
			case (phase)
				PH_SYN: begin
					if (got && rhdr == swsu_pkg::RHDR_SYN_ACK && rseq == 0) begin
						next_seq = swsu_pkg::SEQ_W'(1);
						send_data_or_fin();
					end else begin
						push_packet(swsu_pkg::KIND_SYN, swsu_pkg::HDR_SYN, '0, 8'h00);
					end
				end
				PH_DATA: begin
					if (got && rhdr == swsu_pkg::RHDR_ACK)
						next_seq = {1'b0, rseq} + 1'b1;
					send_data_or_fin();
				end
				default: begin
					if (got && rhdr == swsu_pkg::RHDR_FIN_ACK) begin
						close_link(swsu_pkg::KIND_FINISHED);
					end else if (fin_count >= fin_tries) begin
						close_link(swsu_pkg::KIND_GAVE_UP);
					end else begin
						fin_count++;
						push_packet(swsu_pkg::KIND_FIN, swsu_pkg::HDR_FIN, next_seq, 8'h00);
					end
				end
			endcase
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function void check_packet(logic [47:0] d, logic [2:0] k);
			packet_t got;
			packet_t exp;
			got.kind = k;
			got.hdr  = d[1:0];
			got.seq  = d[34:2];
			got.data = d[42:35];
			if (packets_due.size() == 0) begin
				note_mismatch($sformatf("unexpected packet kind=%0d hdr=%0d seq=%0h data=%02h",
					got.kind, got.hdr, got.seq, got.data));
				return;
			end
			exp = packets_due.pop_front();
			if (got.kind !== exp.kind || got.hdr !== exp.hdr || got.seq !== exp.seq ||
					got.data !== exp.data)
				note_mismatch($sformatf(
					"exp kind=%0d hdr=%0d seq=%0h data=%02h, got kind=%0d hdr=%0d seq=%0h data=%02h",
					exp.kind, exp.hdr, exp.seq, exp.data, got.kind, got.hdr, got.seq, got.data));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = swsu_pkg::CMD_LOAD;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	sender_mirror mirror;
	bit           steady = 0;
	int           quiet_cycles = 0;

	stop_and_wait_sender_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_packet(m_tdata, m_tuser);
		m_tready <= steady || ($urandom_range(99) >= 25);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 2000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one request, wait for its handshake, leave tvalid high
	task automatic send_request(logic [1:0] cmd, logic [7:0] b, logic [7:0] rh,
			logic [swsu_pkg::RSEQ_W-1:0] rs);
		int gap;
		gap = (!steady && $urandom_range(99) < 13) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {rs, rh, b};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		mirror.take_request(cmd, b, rh, rs);
	endtask

	task automatic send_reply(logic [7:0] rh, logic [swsu_pkg::RSEQ_W-1:0] rs);
		send_request(swsu_pkg::CMD_REPLY, 8'($urandom_range(0, 255)), rh, rs);
	endtask

	task automatic send_timeout();
		send_request(swsu_pkg::CMD_TIMEOUT, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), $urandom());
	endtask

	task automatic send_load(logic [7:0] b);
		send_request(swsu_pkg::CMD_LOAD, b, 8'($urandom_range(0, 255)), $urandom());
	endtask

	task automatic send_start();
		send_request(swsu_pkg::CMD_START, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), $urandom());
	endtask

	// hold off until every predicted packet has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (mirror.packets_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_fin_tries(logic [7:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.fin_tries = v;
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] v;
		do
			v = 8'($urandom_range(1, 255));
		while (v == swsu_pkg::BYTE_LF);
		return v;
	endfunction

	// load n bytes and any terminator, then carry the link through handshake, data and teardown
	task automatic run_message(int n, int term, bit plain, bit stubborn);
		int         r;
		logic [7:0] rh;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8) begin
				if ($urandom_range(1))
					send_timeout();
				else
					send_reply(8'($urandom_range(0, 255)), $urandom());
			end
			if (plain || $urandom_range(99) >= 5)
				send_load(plain_char());
			else
				send_load(8'($urandom_range(0, 255)));
		end
		if (term == 1)
			send_load(swsu_pkg::BYTE_NUL);
		else if (term == 2)
			send_load(swsu_pkg::BYTE_LF);
		send_start();
		while (mirror.phase != PH_IDLE) begin
			r = $urandom_range(99);
			if (r < 4) begin
				if ($urandom_range(1))
					send_start();
				else
					send_load(8'($urandom_range(0, 255)));
			end else if (r < 6) begin
				settle();
			end else begin
				case (mirror.phase)
					PH_SYN: begin
						if (r < 20)
							send_timeout();
						else if (r < 30)
							send_reply(8'($urandom_range(0, 255)), $urandom());
						else if (r < 36)
							send_reply(swsu_pkg::RHDR_SYN_ACK,
								$urandom_range(1, 32'hFFFF_FFFF));
						else
							send_reply(swsu_pkg::RHDR_SYN_ACK, '0);
					end
					PH_DATA: begin
						if (r < 14)
							send_timeout();
						else if (r < 22)
							send_reply(8'($urandom_range(0, 255)), $urandom());
						else if (r < 28)
							send_reply(swsu_pkg::RHDR_ACK,
								$urandom_range(0, mirror.loaded + 1));
						else if (r < 31)
							send_reply(swsu_pkg::RHDR_ACK,
								32'(mirror.loaded - 1 + $urandom_range(0, 1)));
						else if (r < 33)
							send_reply(swsu_pkg::RHDR_ACK, $urandom());
						else
							send_reply(swsu_pkg::RHDR_ACK,
								mirror.next_seq[swsu_pkg::RSEQ_W-1:0]);
					end
					default: begin
						if (stubborn || r < 30) begin
							rh = 8'($urandom_range(0, 255));
							if (rh == swsu_pkg::RHDR_FIN_ACK)
								rh = 8'h55;
							if ($urandom_range(1))
								send_timeout();
							else
								send_reply(rh, $urandom());
						end else begin
							send_reply(swsu_pkg::RHDR_FIN_ACK, $urandom());
						end
					end
				endcase
			end
		end
	endtask

	initial begin
		int msg_idx;
		logic [7:0] tries;
		mirror = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// replies while idle are dropped
		send_reply(8'hFF, 32'hFFFF_FFFF);
		send_timeout();
		// full session ending at a newline, with resend and busy requests
		send_load(8'h41);
		send_load(8'hFF);
		send_load(swsu_pkg::BYTE_LF);
		send_start();
		send_timeout();
		send_reply(swsu_pkg::RHDR_SYN_ACK, 32'd1);
		send_reply(swsu_pkg::RHDR_SYN_ACK, 32'd0);
		send_load(8'h33);
		send_start();
		send_reply(swsu_pkg::RHDR_ACK, 32'd1);
		send_timeout();
		send_reply(swsu_pkg::RHDR_ACK, 32'd2);
		send_reply(swsu_pkg::RHDR_FIN_ACK, 32'd0);
		// one FIN try, ack past the message with the widest seq
		write_fin_tries(8'd1);
		send_load(8'h7E);
		send_start();
		send_reply(swsu_pkg::RHDR_SYN_ACK, 32'd0);
		send_reply(swsu_pkg::RHDR_ACK, 32'hFFFF_FFFF);
		send_timeout();
		// zero tries behaves as one; empty message goes straight to FIN
		write_fin_tries(8'd0);
		send_start();
		send_reply(swsu_pkg::RHDR_SYN_ACK, 32'd0);
		send_reply(8'h00, 32'd0);

		msg_idx = 0;
		while (mirror.requests < 700) begin
			if (msg_idx % 4 == 0) begin
				case ($urandom_range(5))
					0: tries = 8'd1;
					1: tries = 8'd2;
					2: tries = 8'd255;
					3: tries = swsu_pkg::FIN_TRIES_RESET;
					4: tries = 8'($urandom_range(1, 254));
					default: tries = 8'd0;
				endcase
				write_fin_tries(tries);
			end
			steady = (msg_idx >= 10 && msg_idx < 14);
			if (msg_idx == 6)
				run_message(40, 0, 1, 0);
			else
				run_message($urandom_range(0, 12), $urandom_range(0, 2),
					$urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
			msg_idx++;
		end
		steady = 0;

		settle();
		repeat (10) @(posedge clk);
		if (mirror.packets_due.size() != 0)
			mirror.note_mismatch($sformatf("%0d packets never came out",
				mirror.packets_due.size()));
		if (mirror.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
